/* rtl/ndtt_pkg.sv */
// ndtt_pkg: shared types and constants of the node distance/time table.
// Used by the channel interfaces, the arithmetic units and the top level.
// No dependencies.
package ndtt_pkg;

  // Table geometry
  localparam int MaxNodes  = 256;
  localparam int IdW       = 8;
  localparam int AddrW     = $clog2(MaxNodes);
  localparam int CoordBits = 16;

  // Arithmetic widths
  localparam int SumW    = 2 * CoordBits + 1;
  localparam int DistW   = 17;
  localparam int VelW    = 16;
  localparam int VelFrac = 8;
  localparam int TimeW   = DistW + VelFrac;
  localparam int SqCntW  = $clog2(DistW);
  localparam int DivCntW = $clog2(TimeW);

  // Configuration port
  localparam int                PAddrW      = 3;
  localparam int                PDataW      = 32;
  localparam logic [0:0]        RegVelocity = 1'b0;
  localparam logic [VelW-1:0]   VelReset    = VelW'(256);

  typedef enum logic {
    KindLoad  = 1'b0,
    KindQuery = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [IdW-1:0]       node_id;
    logic [CoordBits-1:0] coord_x;
    logic [CoordBits-1:0] coord_y;
    logic [IdW-1:0]       from_node;
    logic [IdW-1:0]       to_node;
  } req_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [TimeW-1:0] travel_time;
    logic             bad_id;
  } rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StRdB,
    StDiff,
    StSqX,
    StSqY,
    StSum,
    StSqrt,
    StDiv,
    StDone
  } state_e;

endpackage

/* rtl/ndtt_if.sv */
// ndtt_if: valid/ready channel interfaces for request and result items.
// Depends on ndtt_pkg for the payload types.
interface ndtt_req_if;
  logic           valid;
  logic           ready;
  ndtt_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ndtt_rsp_if;
  logic           valid;
  logic           ready;
  ndtt_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ndtt_ram.sv */
// ndtt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ndtt_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ndtt_sqrt.sv */
// ndtt_sqrt: iterative integer square root, one root bit per cycle.
// Depends on ndtt_pkg for widths.
module ndtt_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ndtt_pkg::SumW-1:0]  radicand_i,
  output logic                       done_o,
  output logic [ndtt_pkg::DistW-1:0] root_o
);
  import ndtt_pkg::*;

  logic [2*DistW-1:0] val_q, val_d;
  logic [DistW+2:0]   rem_q, rem_d;
  logic [DistW-1:0]   root_q, root_d;
  logic [SqCntW-1:0]  cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DistW+2:0]   rem_sh;
  logic [DistW+2:0]   trial;

  // Bring in two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem_q[DistW:0], val_q[2*DistW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      val_d  = (2*DistW)'(radicand_i);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[DistW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[DistW-2:0], 1'b0};
      end
      val_d = {val_q[2*DistW-3:0], 2'b00};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == SqCntW'(DistW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* rtl/ndtt_div.sv */
// ndtt_div: restoring divider, one quotient bit per cycle.
// A zero divisor yields an all-ones quotient. Depends on ndtt_pkg for widths.
module ndtt_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [ndtt_pkg::DistW-1:0] dist_i,
  input  logic [ndtt_pkg::VelW-1:0]  vel_i,
  output logic                       done_o,
  output logic [ndtt_pkg::TimeW-1:0] quot_o
);
  import ndtt_pkg::*;

  logic [TimeW-1:0]   num_q, num_d;
  logic [VelW-1:0]    rem_q, rem_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [VelW:0]      part;
  logic [VelW:0]      diff;
  logic               ge;

  // Shift in the next dividend bit and subtract the divisor where it fits
  always_comb begin
    part   = {rem_q, num_q[TimeW-1]};
    diff   = part - {1'b0, vel_i};
    ge     = part >= {1'b0, vel_i};
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = {dist_i, {VelFrac{1'b0}}};
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[VelW-1:0] : part[VelW-1:0];
      num_d = {num_q[TimeW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(TimeW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

/* rtl/node_distance_time_table_unit.sv */
// Node distance/time table: a load item is accepted in the idle state and gives no result.
// A query item reads both slots, forms the differences and squares, then runs the square
// root and the divider before its result is loaded into the output register; a query with
// an unloaded slot skips straight to the result. No new item is taken until then.
// A held result stalls the next query in its last state. Reset (async, active low) clears
// all slot valid bits, sets velocity to 1.0 and leaves the coordinate RAM as it is.
module node_distance_time_table_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ndtt_req_if.sink                    req_if,
  ndtt_rsp_if.source                  rsp_if,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [ndtt_pkg::PAddrW-1:0] paddr_i,
  input  logic [ndtt_pkg::PDataW-1:0] pwdata_i,
  output logic [ndtt_pkg::PDataW-1:0] prdata_o,
  output logic                        pready_o
);
  import ndtt_pkg::*;

  state_e               state_q, state_d;
  logic [VelW-1:0]      vel_q;
  logic [MaxNodes-1:0]  slot_valid_q;
  logic [AddrW-1:0]     to_q;
  logic [CoordBits-1:0] ax_q, ay_q, dx_q, dy_q;
  logic [2*CoordBits-1:0] sx_q, sy_q;
  logic                 bad_q;
  rsp_t                 rsp_q;
  logic                 rsp_valid_q;

  logic                 req_acc, load_acc, query_acc;
  logic                 from_ok, to_ok, bad_d;
  logic                 ram_we;
  logic [AddrW-1:0]     ram_raddr;
  logic [2*CoordBits-1:0] ram_wdata, ram_rdata;
  logic [CoordBits-1:0] bx, by;
  logic                 sq_start, sq_done, dv_start, dv_done, rsp_load;
  logic [SumW-1:0]      sum;
  logic [DistW-1:0]     root;
  logic [TimeW-1:0]     quot;

  // Configuration register
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == RegVelocity) ? PDataW'(vel_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q <= VelReset;
    end else if (psel_i && penable_i && pwrite_i && paddr_i[2] == RegVelocity) begin
      vel_q <= pwdata_i[VelW-1:0];
    end
  end

  // Input handshake and slot checks
  assign req_if.ready = (state_q == StIdle);
  assign req_acc      = req_if.valid && req_if.ready;
  assign load_acc     = req_acc && req_if.data.kind == KindLoad;
  assign query_acc    = req_acc && req_if.data.kind == KindQuery;
  assign from_ok      = 32'(req_if.data.from_node) < MaxNodes;
  assign to_ok        = 32'(req_if.data.to_node) < MaxNodes;
  assign bad_d = !from_ok || !to_ok ||
                 !slot_valid_q[req_if.data.from_node[AddrW-1:0]] ||
                 !slot_valid_q[req_if.data.to_node[AddrW-1:0]];

  // Coordinate store: x in the upper half, y in the lower
  assign ram_we    = load_acc && 32'(req_if.data.node_id) < MaxNodes;
  assign ram_wdata = {req_if.data.coord_x, req_if.data.coord_y};
  assign ram_raddr = (state_q == StIdle) ? req_if.data.from_node[AddrW-1:0] : to_q;

  ndtt_ram #(
    .Width (2 * CoordBits),
    .Depth (MaxNodes)
  ) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (req_if.data.node_id[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign bx = ram_rdata[2*CoordBits-1:CoordBits];
  assign by = ram_rdata[CoordBits-1:0];

  // Slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else if (ram_we) begin
      slot_valid_q[req_if.data.node_id[AddrW-1:0]] <= 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      to_q  <= req_if.data.to_node[AddrW-1:0];
      bad_q <= bad_d;
    end
    if (state_q == StRdB) begin
      ax_q <= bx;
      ay_q <= by;
    end
    if (state_q == StDiff) begin
      dx_q <= (ax_q >= bx) ? ax_q - bx : bx - ax_q;
      dy_q <= (ay_q >= by) ? ay_q - by : by - ay_q;
    end
    if (state_q == StSqX) begin
      sx_q <= dx_q * dx_q;
    end
    if (state_q == StSqY) begin
      sy_q <= dy_q * dy_q;
    end
  end

  assign sum = {1'b0, sx_q} + {1'b0, sy_q};

  ndtt_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sum),
    .done_o     (sq_done),
    .root_o     (root)
  );

  ndtt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .dist_i  (root),
    .vel_i   (vel_q),
    .done_o  (dv_done),
    .quot_o  (quot)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    sq_start = 1'b0;
    dv_start = 1'b0;
    rsp_load = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (query_acc) begin
          state_d = bad_d ? StDone : StRdB;
        end
      end
      StRdB:  state_d = StDiff;
      StDiff: state_d = StSqX;
      StSqX:  state_d = StSqY;
      StSqY:  state_d = StSum;
      StSum: begin
        sq_start = 1'b1;
        state_d  = StSqrt;
      end
      StSqrt: begin
        if (sq_done) begin
          dv_start = 1'b1;
          state_d  = StDiv;
        end
      end
      StDiv: begin
        if (dv_done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!rsp_valid_q || rsp_if.ready) begin
          rsp_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output register: hold the item until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_if.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_q.bad_id      <= bad_q;
      rsp_q.distance    <= bad_q ? '0 : root;
      rsp_q.travel_time <= bad_q ? '0 : quot;
    end
  end

  assign rsp_if.valid = rsp_valid_q;
  assign rsp_if.data  = rsp_q;

  // Checks
  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_acc |=> state_q == StIdle)
    else $error("load item started a computation");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_q.bad_id |-> rsp_q.distance == '0 && rsp_q.travel_time == '0)
    else $error("error result carries nonzero distance or time");

  a_sqrt_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == StSqrt)
    else $error("square root finished outside its wait state");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_done |-> state_q == StDiv)
    else $error("divider finished outside its wait state");

  a_bad_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_acc && bad_d |=> state_q == StDone)
    else $error("query with unloaded slot did not skip to result");

endmodule
